// ===== design/lri_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and the sigmoid lookup table for the logistic regression core.
// The table is built at elaboration from a fixed-point exponential series.
// Depends on nothing; the core top level, front end and back end import it.
package lri_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int CH_ADDR_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W = $clog2(SIG_ENTRIES);

    localparam int WEIGHT_W = 24;
    localparam int COUNT_W = 16;
    localparam int RECIP_W = 17;
    localparam int PROB_W = 16;
    localparam int FEAT_W = 34;
    localparam int PROD_W = FEAT_W + WEIGHT_W;
    localparam int TERM_W = PROD_W - 16;
    localparam int ACC_W = 48;
    localparam int Z_W = ACC_W + 1;
    localparam int Z_SPAN_W = 20;

    localparam logic signed [Z_W-1:0] Z_OFFSET = Z_W'(64'd1 << (Z_SPAN_W - 1));
    localparam logic [PROB_W-1:0] PROB_HALF = PROB_W'(32768);

    typedef struct packed {
        logic                 is_sample;
        logic                 in_range;
        logic [CH_ADDR_W-1:0] addr;
        logic [WEIGHT_W-1:0]  weight;
        logic [COUNT_W-1:0]   min_value;
        logic [RECIP_W-1:0]   recip_range;
        logic [COUNT_W-1:0]   spike_count;
        logic                 last;
    } lri_item_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [COUNT_W-1:0]  min_value;
        logic [RECIP_W-1:0]  recip_range;
    } lri_coef_t;

    typedef logic [SIG_ENTRIES-1:0][PROB_W-1:0] lri_sig_table_t;

    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_q24(logic [63:0] x_q16);
        logic [63:0] y;
        logic [63:0] s;
        logic [63:0] t;
        y = x_q16 << 4;
        s = 64'd1 << 24;
        t = 64'd1 << 24;
        for (int k = 1; k <= 12; k++) begin
            t = udiv64((t * y) >> 24, 64'(k));
            s = s + t;
        end
        for (int k = 0; k < 4; k++) begin
            s = (s * s) >> 24;
        end
        return s;
    endfunction

    function automatic lri_sig_table_t build_sig_table();
        lri_sig_table_t tbl;
        longint zc;
        logic [63:0] ax;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] s;
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            zc = -(longint'(1) << 19) + ((longint'(2 * i + 1)) << 19) / SIG_ENTRIES;
            ax = (zc < 0) ? 64'(-zc) : 64'(zc);
            if (ax > (64'd8 << 16)) begin
                ax = 64'd8 << 16;
            end
            e = exp_q24(ax);
            den = e + (64'd1 << 24);
            if (zc >= 0) begin
                s = udiv64((e << 16) + (den >> 1), den);
            end else begin
                s = udiv64((64'd1 << 40) + (den >> 1), den);
            end
            if (s > 64'd65535) begin
                s = 64'd65535;
            end
            tbl[i] = s[PROB_W-1:0];
        end
        return tbl;
    endfunction

    localparam lri_sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ===== design/logistic_regression_infer_core.sv =====
`timescale 1ns / 1ps
// Top level of the min-max scaled logistic regression core: bias register, front queue, back end.
// Depends on lri_pkg, lri_front and lri_back.
// A load transaction is taken in the idle state and written to the coefficient memory; a sample passes
// the feature, product and accumulate states of the two-multiply sequencer behind the single-port coefficient memory.
// A final sample also passes the finish state, which waits until the output register is free, then shows its result.
// Reset clears the queue, sequencer, accumulator, bias and output valid; coefficients need loading.
module logistic_regression_infer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [5:0]         channel_index,
    input  logic signed [23:0] weight,
    input  logic [15:0]        min_value,
    input  logic [16:0]        recip_range,
    input  logic [15:0]        spike_count,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        probability,
    output logic               direction,
    input  logic               cfg_we,
    input  logic signed [23:0] cfg_wdata
);
    import lri_pkg::*;

    logic signed [WEIGHT_W-1:0] bias_reg;
    logic                       q_valid;
    logic                       q_ready;
    lri_item_t                  q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
        end
        else if (cfg_we)
        begin
            bias_reg <= cfg_wdata;
        end
    end

    lri_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .channel_index (channel_index),
        .weight        (weight),
        .min_value     (min_value),
        .recip_range   (recip_range),
        .spike_count   (spike_count),
        .last          (last),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    lri_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .bias        (bias_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .probability (probability),
        .direction   (direction)
    );

endmodule

// ===== design/lri_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies them and holds them in a two-entry queue.
// Depends on lri_pkg for the queued item type.
module lri_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [5:0]            channel_index,
    input  logic signed [23:0]    weight,
    input  logic [15:0]           min_value,
    input  logic [16:0]           recip_range,
    input  logic [15:0]           spike_count,
    input  logic                  last,
    output logic                  q_valid,
    input  logic                  q_ready,
    output lri_pkg::lri_item_t    q_item
);
    import lri_pkg::*;

    lri_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    lri_item_t  item_in;

    always_comb
    begin
        item_in.is_sample   = kind;
        item_in.in_range    = (32'(channel_index) < MAX_CHANNELS);
        item_in.addr        = CH_ADDR_W'(channel_index);
        item_in.weight      = weight;
        item_in.min_value   = min_value;
        item_in.recip_range = recip_range;
        item_in.spike_count = spike_count;
        item_in.last        = last;
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== design/lri_back.sv =====
`timescale 1ns / 1ps
// Back end: coefficient memory, two-multiply feature sequencer, saturating accumulator,
// sigmoid lookup and the output register. Depends on lri_pkg.
module lri_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  lri_pkg::lri_item_t    q_item,
    input  logic signed [23:0]    bias,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           probability,
    output logic                  direction
);
    import lri_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FEAT = 3'd1;
    localparam logic [2:0] ST_PROD = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    lri_coef_t coef_mem [MAX_CHANNELS];
    lri_coef_t coef_rd_reg;
    lri_coef_t coef_wr;
    logic      mem_we;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [COUNT_W-1:0] count_reg;
    logic       last_reg;
    logic       range_reg;
    logic signed [FEAT_W-1:0]   feat_reg;
    logic signed [FEAT_W-1:0]   feat_next;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic signed [TERM_W-1:0]   term_reg;
    logic signed [TERM_W-1:0]   term_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [PROB_W-1:0]          prob_reg;
    logic                       dir_reg;

    logic signed [16:0]         diff;
    logic signed [17:0]         recip_s;
    logic signed [FEAT_W:0]     feat_full;
    logic signed [PROD_W-1:0]   prod;
    logic signed [Z_W-1:0]      sum;
    logic signed [Z_W-1:0]      z;
    logic signed [Z_W-1:0]      z_off;
    logic [SIG_IDX_W-1:0]       sig_idx;
    logic [PROB_W-1:0]          prob_next;
    logic                       fin_go;

    assign q_ready     = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign probability = prob_reg;
    assign direction   = dir_reg;

    assign coef_wr.weight      = q_item.weight;
    assign coef_wr.min_value   = q_item.min_value;
    assign coef_wr.recip_range = q_item.recip_range;
    assign mem_we = (state_reg == ST_IDLE) && q_valid && !q_item.is_sample && q_item.in_range;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            coef_mem[q_item.addr] <= coef_wr;
        end
        coef_rd_reg <= coef_mem[q_item.addr];
    end

    always_comb
    begin
        diff      = signed'({1'b0, count_reg}) - signed'({1'b0, coef_rd_reg.min_value});
        recip_s   = signed'({1'b0, coef_rd_reg.recip_range});
        feat_full = diff * recip_s;
        feat_next = feat_full[FEAT_W-1:0];
        prod      = feat_reg * weight_reg;
        term_next = range_reg ? prod[PROD_W-1:16] : '0;

        sum = Z_W'(acc_reg) + Z_W'(term_reg);
        if (sum[Z_W-1] != sum[Z_W-2])
        begin
            acc_next = sum[Z_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            acc_next = sum[ACC_W-1:0];
        end

        z     = Z_W'(acc_reg) + Z_W'(bias);
        z_off = z + Z_OFFSET;
        priority if (z_off[Z_W-1])
        begin
            sig_idx = '0;
        end
        else if (z_off[Z_W-2:Z_SPAN_W] != '0)
        begin
            sig_idx = '1;
        end
        else
        begin
            sig_idx = z_off[Z_SPAN_W-1 -: SIG_IDX_W];
        end
        prob_next = SIG_TABLE[sig_idx];
    end

    assign fin_go = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_item.is_sample)
                begin
                    state_next = ST_FEAT;
                end
            end
            ST_FEAT:
            begin
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_ACC)
            begin
                acc_reg <= acc_next;
            end
            else if (fin_go)
            begin
                acc_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            count_reg <= q_item.spike_count;
            last_reg  <= q_item.last;
            range_reg <= q_item.in_range;
        end
        if (state_reg == ST_FEAT)
        begin
            feat_reg   <= feat_next;
            weight_reg <= signed'(coef_rd_reg.weight);
        end
        if (state_reg == ST_PROD)
        begin
            term_reg <= term_next;
        end
        if (fin_go)
        begin
            prob_reg <= prob_next;
            dir_reg  <= (prob_next > PROB_HALF);
        end
    end

endmodule

// ===== design/lri_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the logistic regression core, bound to the top level.
// Depends only on the top-level port list.
module lri_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] probability,
    input logic        direction
);

    a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result transaction dropped before acceptance");

    a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(probability) && $stable(direction))
        else $error("result payload changed while stalled");

    a_direction_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (direction == (probability > 16'd32768)))
        else $error("direction disagrees with probability");

endmodule

bind logistic_regression_infer_core lri_checker u_lri_checker (.*);

// ===== tb/logistic_regression_infer_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for logistic_regression_infer_core: a directed table, then random windows
// under three idle patterns, each result compared with a cycle-free fixed-point predictor or with
// the typed score of a directed row. Depends on lri_pkg for widths and on the core itself.
module logistic_regression_infer_core_tb;
    import lri_pkg::*;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;
    localparam logic [PROB_W-1:0] PROB_TOP = 16'd65513;
    localparam logic [PROB_W-1:0] PROB_FLOOR = 16'd23;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS = 112;
    localparam int SAT_SAMPLES = 264;
    localparam int N_DIRECTED = 20;
    localparam longint SUM_HI = (longint'(1) <<< 47) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< 47);
    localparam longint Z_HALF_SPAN = longint'(1) <<< 19;

    typedef struct packed {
        logic                 kind;
        logic [CH_ADDR_W-1:0] ch;
        logic [WEIGHT_W-1:0]  w;
        logic [COUNT_W-1:0]   mn;
        logic [RECIP_W-1:0]   rc;
        logic [COUNT_W-1:0]   cnt;
        logic                 lst;
    } txn_t;

    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic              dir;
    } score_t;

    typedef struct packed {
        logic                is_cfg;
        logic [WEIGHT_W-1:0] bias;
        txn_t                txn;
        logic                typed;
        score_t              score;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic [5:0] channel_index = '0;
    logic signed [23:0] weight = '0;
    logic [15:0] min_value = '0;
    logic [16:0] recip_range = '0;
    logic [15:0] spike_count = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [15:0] probability;
    logic direction;
    logic cfg_we = 1'b0;
    logic signed [23:0] cfg_wdata = '0;

    logic [PROB_W-1:0] sigmoid_lut [SIG_ENTRIES];
    logic signed [WEIGHT_W-1:0] coef_weight [MAX_CHANNELS];
    logic [COUNT_W-1:0] coef_min [MAX_CHANNELS];
    logic [RECIP_W-1:0] coef_recip [MAX_CHANNELS];
    longint window_sum = 0;
    logic signed [WEIGHT_W-1:0] bias_reg = '0;

    score_t pending_scores [$];
    logic [CH_ADDR_W-1:0] loaded_list [$];
    bit chan_loaded [MAX_CHANNELS];
    int chan_min [MAX_CHANNELS];
    int chan_span [MAX_CHANNELS];
    row_t directed_rows [N_DIRECTED];

    int send_idle_pct = 34;
    int recv_stall_pct = 85;
    int mismatches = 0;
    int txn_count = 0;
    int results_checked = 0;
    int bias_writes = 0;

    logistic_regression_infer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .channel_index(channel_index),
        .weight       (weight),
        .min_value    (min_value),
        .recip_range  (recip_range),
        .spike_count  (spike_count),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .probability  (probability),
        .direction    (direction),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint unsigned series_exp(input longint unsigned x_q16);
        longint unsigned y;
        longint unsigned total;
        longint unsigned term;
        y = x_q16 << 4;
        total = 64'd1 << 24;
        term = 64'd1 << 24;
        for (int k = 1; k <= 12; k++)
        begin
            term = ((term * y) >> 24) / 64'(k);
            total = total + term;
        end
        for (int k = 0; k < 4; k++)
        begin
            total = (total * total) >> 24;
        end
        return total;
    endfunction

    task automatic init_sigmoid();
        longint zc;
        longint unsigned mag;
        longint unsigned e;
        longint unsigned den;
        longint unsigned s;
        for (int i = 0; i < SIG_ENTRIES; i++)
        begin
            zc = -Z_HALF_SPAN + (longint'(2 * i + 1) <<< 19) / SIG_ENTRIES;
            mag = (zc < 0) ? 64'(-zc) : 64'(zc);
            if (mag > (64'd8 << 16))
            begin
                mag = 64'd8 << 16;
            end
            e = series_exp(mag);
            den = e + (64'd1 << 24);
            if (zc >= 0)
            begin
                s = ((e << 16) + (den >> 1)) / den;
            end
            else
            begin
                s = ((64'd1 << 40) + (den >> 1)) / den;
            end
            if (s > 64'd65535)
            begin
                s = 64'd65535;
            end
            sigmoid_lut[i] = s[PROB_W-1:0];
        end
    endtask

    task automatic predict_probability(input txn_t t, output bit has_score, output score_t s);
        longint diff;
        longint feat;
        longint prod;
        longint z;
        int idx;
        has_score = 1'b0;
        s = '0;
        if (t.kind == KIND_LOAD)
        begin
            coef_weight[t.ch] = t.w;
            coef_min[t.ch] = t.mn;
            coef_recip[t.ch] = t.rc;
        end
        else
        begin
            diff = longint'(t.cnt) - longint'(coef_min[t.ch]);
            feat = diff * longint'(coef_recip[t.ch]);
            prod = feat * longint'(coef_weight[t.ch]);
            window_sum = window_sum + (prod >>> 16);
            if (window_sum > SUM_HI)
            begin
                window_sum = SUM_HI;
            end
            if (window_sum < SUM_LO)
            begin
                window_sum = SUM_LO;
            end
            if (t.lst)
            begin
                z = window_sum + longint'(bias_reg);
                window_sum = 0;
                if (z < -Z_HALF_SPAN)
                begin
                    idx = 0;
                end
                else if (z >= Z_HALF_SPAN)
                begin
                    idx = SIG_ENTRIES - 1;
                end
                else
                begin
                    idx = int'(((z + Z_HALF_SPAN) * SIG_ENTRIES) >>> 20);
                end
                s.prob = sigmoid_lut[idx];
                s.dir = (s.prob > 16'd32768);
                has_score = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_score();
        score_t want;
        if (pending_scores.size() == 0)
        begin
            report_mismatch($sformatf("result prob=%0d dir=%0d with nothing expected",
                                      probability, direction));
        end
        else
        begin
            want = pending_scores.pop_front();
            if (probability !== want.prob)
            begin
                report_mismatch($sformatf("probability %0d, expected %0d", probability,
                                          want.prob));
            end
            if (direction !== want.dir)
            begin
                report_mismatch($sformatf("direction %0d, expected %0d", direction, want.dir));
            end
            results_checked++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_score();
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_txn(input txn_t t, input logic typed, input score_t typed_score);
        bit has_score;
        score_t s;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= t.kind;
        channel_index <= t.ch;
        weight <= t.w;
        min_value <= t.mn;
        recip_range <= t.rc;
        spike_count <= t.cnt;
        last <= t.lst;
        do @(posedge clk); while (!in_ready);
        predict_probability(t, has_score, s);
        if (has_score)
        begin
            pending_scores = {pending_scores, (typed ? typed_score : s)};
        end
        if (t.kind == KIND_LOAD)
        begin
            if (!chan_loaded[t.ch])
            begin
                chan_loaded[t.ch] = 1'b1;
                loaded_list = {loaded_list, t.ch};
            end
            chan_min[t.ch] = int'(t.mn);
            chan_span[t.ch] = (t.rc == '0) ? 1000 : 65536 / int'(t.rc);
        end
        txn_count++;
    endtask

    task automatic settle(input int extra);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_scores.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_bias(input logic [WEIGHT_W-1:0] b);
        cfg_wdata <= b;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        bias_reg = b;
        bias_writes++;
    endtask

    function automatic row_t load_row(input int ch, input int w, input int mn, input int rc,
                                      input logic lst);
        row_t r;
        r = '0;
        r.txn.kind = KIND_LOAD;
        r.txn.ch = CH_ADDR_W'(ch);
        r.txn.w = WEIGHT_W'(w);
        r.txn.mn = COUNT_W'(mn);
        r.txn.rc = RECIP_W'(rc);
        r.txn.lst = lst;
        return r;
    endfunction

    function automatic row_t sample_row(input int ch, input int cnt, input logic lst);
        row_t r;
        r = '0;
        r.txn.kind = KIND_SAMPLE;
        r.txn.ch = CH_ADDR_W'(ch);
        r.txn.cnt = COUNT_W'(cnt);
        r.txn.lst = lst;
        return r;
    endfunction

    function automatic row_t sample_typed(input int ch, input int cnt,
                                          input logic [PROB_W-1:0] p, input logic d);
        row_t r;
        r = sample_row(ch, cnt, 1'b1);
        r.typed = 1'b1;
        r.score.prob = p;
        r.score.dir = d;
        return r;
    endfunction

    function automatic row_t bias_row(input int b);
        row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.bias = WEIGHT_W'(b);
        return r;
    endfunction

    function automatic logic [CH_ADDR_W-1:0] pick_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    task automatic gen_model_load(output txn_t t);
        int span;
        span = int'($urandom_range(4000, 1));
        t = '0;
        t.kind = KIND_LOAD;
        t.ch = CH_ADDR_W'($urandom_range(MAX_CHANNELS - 1));
        t.w = WEIGHT_W'($urandom_range(196608) - 98304);
        t.mn = COUNT_W'($urandom_range(2000));
        t.rc = ($urandom_range(9) == 0) ? '0 : RECIP_W'(65536 / span);
        t.cnt = COUNT_W'($urandom);
        t.lst = 1'($urandom_range(1));
    endtask

    task automatic gen_window_sample(input logic lst, output txn_t t);
        int v;
        t.kind = KIND_SAMPLE;
        t.ch = pick_loaded();
        t.w = WEIGHT_W'($urandom);
        t.mn = COUNT_W'($urandom);
        t.rc = RECIP_W'($urandom_range(65536));
        if ($urandom_range(9) == 0)
        begin
            v = chan_min[t.ch] - int'($urandom_range(100, 1));
        end
        else
        begin
            v = chan_min[t.ch] + int'($urandom_range(chan_span[t.ch]));
        end
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 65535)
        begin
            v = 65535;
        end
        t.cnt = COUNT_W'(v);
        t.lst = lst;
    endtask

    task automatic gen_noise(output txn_t t);
        t.kind = 1'($urandom_range(1));
        t.ch = (t.kind == KIND_LOAD) ? CH_ADDR_W'($urandom_range(MAX_CHANNELS - 1))
                                     : pick_loaded();
        t.w = WEIGHT_W'($urandom);
        t.mn = COUNT_W'($urandom);
        t.rc = RECIP_W'($urandom_range(65536));
        t.cnt = COUNT_W'($urandom);
        t.lst = 1'($urandom_range(1));
    endtask

    task automatic sat_burst(input logic negative);
        txn_t t;
        t = '0;
        t.kind = KIND_LOAD;
        t.ch = CH_ADDR_W'($urandom_range(MAX_CHANNELS - 1));
        t.w = negative ? WEIGHT_W'(-8388608) : WEIGHT_W'(8388607);
        t.mn = '0;
        t.rc = RECIP_W'(65536);
        send_txn(t, 1'b0, '0);
        t.kind = KIND_SAMPLE;
        t.cnt = 16'hFFFF;
        repeat (SAT_SAMPLES) send_txn(t, 1'b0, '0);
        t.cnt = '0;
        t.lst = 1'b1;
        send_txn(t, 1'b0, '0);
    endtask

    initial
    begin
        txn_t t;
        int pick;
        int len;
        int phase_start;
        bit paused;
        init_sigmoid();
        directed_rows = '{
            load_row(0, 8388607, 0, 65536, 1'b0),
            load_row(63, -8388608, 65535, 65536, 1'b0),
            load_row(1, 65536, 100, 0, 1'b0),
            load_row(2, 65536, 1000, 32768, 1'b0),
            sample_row(1, 5000, 1'b1),
            sample_typed(0, 65535, PROB_TOP, 1'b1),
            sample_typed(63, 0, PROB_TOP, 1'b1),
            sample_row(63, 65535, 1'b1),
            sample_row(2, 0, 1'b0),
            sample_typed(2, 0, PROB_FLOOR, 1'b0),
            load_row(3, -65536, 0, 65536, 1'b1),
            sample_row(3, 1, 1'b1),
            sample_row(0, 0, 1'b0),
            sample_row(3, 2, 1'b1),
            bias_row(8388607),
            sample_typed(1, 0, PROB_TOP, 1'b1),
            bias_row(-8388608),
            sample_typed(1, 65535, PROB_FLOOR, 1'b0),
            sample_row(2, 3000, 1'b1),
            bias_row(0)
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                settle(SETTLE_CYCLES);
                write_bias(directed_rows[i].bias);
            end
            else
            begin
                send_txn(directed_rows[i].txn, directed_rows[i].typed, directed_rows[i].score);
            end
        end

        for (int p = 0; p < 6; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle_pct = 34;
                    recv_stall_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_stall_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            settle(SETTLE_CYCLES);
            case (p % 3)
                0: write_bias(WEIGHT_W'($urandom_range(524288) - 262144));
                1: write_bias(WEIGHT_W'($urandom));
                default: write_bias('0);
            endcase
            repeat (12)
            begin
                gen_model_load(t);
                send_txn(t, 1'b0, '0);
            end
            if (p == 1)
            begin
                sat_burst(1'b0);
            end
            if (p == 4)
            begin
                sat_burst(1'b1);
            end
            phase_start = txn_count;
            paused = 1'b0;
            while (txn_count - phase_start < PHASE_ITEMS)
            begin
                if (!paused && txn_count - phase_start >= PHASE_ITEMS / 2)
                begin
                    settle(0);
                    paused = 1'b1;
                end
                pick = int'($urandom_range(99));
                if (pick < 12)
                begin
                    gen_noise(t);
                    send_txn(t, 1'b0, '0);
                end
                else if (pick < 20)
                begin
                    gen_model_load(t);
                    send_txn(t, 1'b0, '0);
                end
                else
                begin
                    len = int'($urandom_range(10, 1));
                    for (int j = 0; j < len; j++)
                    begin
                        gen_window_sample(j == len - 1, t);
                        send_txn(t, 1'b0, '0);
                    end
                end
            end
        end

        settle(SETTLE_CYCLES);
        $display("Summary: %0d transactions (%0d directed rows), %0d results checked.",
                 txn_count, N_DIRECTED, results_checked);
        $display("Windows of 1 to 10 samples, noise, both accumulator limits, %0d bias writes.",
                 bias_writes);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lri_pkg.sv
design/lri_front.sv
design/lri_back.sv
design/logistic_regression_infer_core.sv
design/lri_checker.sv
tb/logistic_regression_infer_core_tb.sv
